>>> sv/icp_pkg.sv
package icp_pkg;

  // one stored point, signed Q16.16
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  // angle constants, Q3.29 radians, and the rotation gain in Q2.30
  localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
  localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic t_read;
    logic scan;
    logic match;
    logic div_start;
    logic div_step;
    logic div_store;
    logic x_read;
    logic x_ctr;
    logic x_mul;
    logic x_next;
    logic ang_init;
    logic ang_half;
    logic vec_load;
    logic vec_step;
    logic ang_set;
    logic sc_init;
    logic rot_step;
    logic sc_fin;
    logic f_mul;
    logic out_load;
    logic finish;
  } icp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic start_empty;
    logic i_last;
    logic scan_done;
    logic div_done;
    logic k_last;
    logic y_zero;
    logic need_half;
    logic it_last;
    logic out_busy;
  } icp_sts_t;

  // arctangent of 2^-i in Q3.29
  function automatic logic [31:0] atan_q29(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd421657428;
      5'd1:  r = 32'd248918915;
      5'd2:  r = 32'd131521918;
      5'd3:  r = 32'd66762579;
      5'd4:  r = 32'd33510843;
      5'd5:  r = 32'd16771758;
      5'd6:  r = 32'd8387925;
      5'd7:  r = 32'd4194219;
      5'd8:  r = 32'd2097141;
      5'd9:  r = 32'd1048575;
      5'd10: r = 32'd524288;
      5'd11: r = 32'd262144;
      5'd12: r = 32'd131072;
      5'd13: r = 32'd65536;
      5'd14: r = 32'd32768;
      5'd15: r = 32'd16384;
      5'd16: r = 32'd8192;
      5'd17: r = 32'd4096;
      5'd18: r = 32'd2048;
      5'd19: r = 32'd1024;
      5'd20: r = 32'd512;
      5'd21: r = 32'd256;
      5'd22: r = 32'd128;
      5'd23: r = 32'd64;
      5'd24: r = 32'd32;
      5'd25: r = 32'd16;
      5'd26: r = 32'd8;
      5'd27: r = 32'd4;
      5'd28: r = 32'd2;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/icp_if.sv
// point input channel
interface icp_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic               last;
  modport source (output valid, kind, x, y, last, input ready);
  modport sink (input valid, kind, x, y, last, output ready);
endinterface

// result output channel
interface icp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic signed [31:0] angle;
  logic [1:0]         status;
  modport source (output valid, shift_x, shift_y, angle, status, input ready);
  modport sink (input valid, shift_x, shift_y, angle, status, output ready);
endinterface

>>> sv/icp_2d_alignment_step.sv
// points load at one per cycle while idle; a target marked last starts the alignment step
// no point is taken during a step; the result waits in an output register
// synchronous active-high reset clears counts, flags and control; stores are not cleared
module icp_2d_alignment_step #(
  parameter int MAX_REFERENCE_POINTS = 256,
  parameter int MAX_TARGET_POINTS    = 256,
  parameter int CORDIC_ITERATIONS    = 24
) (
  input logic       clk,
  input logic       rst,
  icp_in_if.sink    point,
  icp_out_if.source result
);

  icp_pkg::icp_cmd_t cmd;
  icp_pkg::icp_sts_t sts;
  logic              in_ready;
  logic              fire;

  assign point.ready = in_ready;
  assign fire        = point.valid && in_ready;

  icp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .start_req (point.kind && point.last),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  icp_dp #(
    .MAX_REFERENCE_POINTS (MAX_REFERENCE_POINTS),
    .MAX_TARGET_POINTS    (MAX_TARGET_POINTS),
    .CORDIC_ITERATIONS    (CORDIC_ITERATIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (point.kind),
    .in_x      (point.x),
    .in_y      (point.y),
    .in_last   (point.last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .shift_x   (result.shift_x),
    .shift_y   (result.shift_y),
    .angle     (result.angle),
    .status    (result.status)
  );

endmodule

>>> sv/icp_ctrl.sv
module icp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               start_req,
  output logic               in_ready,
  output icp_pkg::icp_cmd_t  cmd,
  input  icp_pkg::icp_sts_t  sts
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_START  = 5'd1;
  localparam logic [4:0] S_TREAD  = 5'd2;
  localparam logic [4:0] S_SCAN   = 5'd3;
  localparam logic [4:0] S_MATCH  = 5'd4;
  localparam logic [4:0] S_DIVGO  = 5'd5;
  localparam logic [4:0] S_DIVRUN = 5'd6;
  localparam logic [4:0] S_XREAD  = 5'd7;
  localparam logic [4:0] S_XCTR   = 5'd8;
  localparam logic [4:0] S_XMUL   = 5'd9;
  localparam logic [4:0] S_XNEXT  = 5'd10;
  localparam logic [4:0] S_AINIT  = 5'd11;
  localparam logic [4:0] S_AHALF  = 5'd12;
  localparam logic [4:0] S_AVEC   = 5'd13;
  localparam logic [4:0] S_ASET   = 5'd14;
  localparam logic [4:0] S_SCINIT = 5'd15;
  localparam logic [4:0] S_SCROT  = 5'd16;
  localparam logic [4:0] S_SCFIN  = 5'd17;
  localparam logic [4:0] S_FMUL   = 5'd18;
  localparam logic [4:0] S_FWAIT  = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  logic [4:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = fire;
        if (fire && start_req) state_next = S_START;
      end
      S_START: begin
        cmd.clr_step = 1'b1;
        state_next   = sts.start_empty ? S_OUT : S_TREAD;
      end
      S_TREAD: begin
        cmd.t_read = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_MATCH;
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = sts.i_last ? S_DIVGO : S_TREAD;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVRUN;
      end
      S_DIVRUN: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = sts.k_last ? S_XREAD : S_DIVGO;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_XREAD: begin
        cmd.x_read = 1'b1;
        state_next = S_XCTR;
      end
      S_XCTR: begin
        cmd.x_ctr  = 1'b1;
        state_next = S_XMUL;
      end
      S_XMUL: begin
        cmd.x_mul = 1'b1;
        if (sts.k_last) state_next = S_XNEXT;
      end
      S_XNEXT: begin
        cmd.x_next = 1'b1;
        state_next = sts.i_last ? S_AINIT : S_XREAD;
      end
      S_AINIT: begin
        cmd.ang_init = 1'b1;
        state_next   = S_AHALF;
      end
      S_AHALF: begin
        if (sts.y_zero) begin
          state_next = S_ASET;
        end else if (sts.need_half) begin
          cmd.ang_half = 1'b1;
        end else begin
          cmd.vec_load = 1'b1;
          state_next   = S_AVEC;
        end
      end
      S_AVEC: begin
        cmd.vec_step = 1'b1;
        if (sts.it_last) state_next = S_ASET;
      end
      S_ASET: begin
        cmd.ang_set = 1'b1;
        state_next  = S_SCINIT;
      end
      S_SCINIT: begin
        cmd.sc_init = 1'b1;
        state_next  = S_SCROT;
      end
      S_SCROT: begin
        cmd.rot_step = 1'b1;
        if (sts.it_last) state_next = S_SCFIN;
      end
      S_SCFIN: begin
        cmd.sc_fin = 1'b1;
        state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.f_mul = 1'b1;
        if (sts.k_last) state_next = S_FWAIT;
      end
      S_FWAIT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/icp_dp.sv
module icp_dp #(
  parameter int MAX_REFERENCE_POINTS = 256,
  parameter int MAX_TARGET_POINTS    = 256,
  parameter int CORDIC_ITERATIONS    = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  icp_pkg::icp_cmd_t  cmd,
  output icp_pkg::icp_sts_t  sts,
  input  logic               in_kind,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] shift_x,
  output logic signed [31:0] shift_y,
  output logic signed [31:0] angle,
  output logic [1:0]         status
);

  localparam int RAW  = (MAX_REFERENCE_POINTS > 1) ? $clog2(MAX_REFERENCE_POINTS) : 1;
  localparam int TAW  = (MAX_TARGET_POINTS > 1) ? $clog2(MAX_TARGET_POINTS) : 1;
  localparam int RCW  = $clog2(MAX_REFERENCE_POINTS + 1);
  localparam int TCW  = $clog2(MAX_TARGET_POINTS + 1);
  localparam int SUMW = 32 + TCW;
  localparam int DCW  = $clog2(SUMW + 1);
  localparam int ITW  = $clog2(CORDIC_ITERATIONS);
  localparam int CW   = 62;
  localparam int ZW   = 34;

  localparam logic signed [64:0] LIM59  = 65'sh0800000000000000;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(icp_pkg::PI_Q29);
  localparam logic signed [ZW-1:0] HP_Z = ZW'(icp_pkg::HALF_PI_Q29);

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic signed [64:0] halve(input logic signed [64:0] v);
    logic signed [64:0] s;
    s = v + $signed({64'b0, v[64]});
    return s >>> 1;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // stores
  icp_pkg::pt_t ref_mem [MAX_REFERENCE_POINTS];
  icp_pkg::pt_t tgt_mem [MAX_TARGET_POINTS];
  icp_pkg::pt_t mat_mem [MAX_TARGET_POINTS];

  logic [RCW-1:0] rc, rc_eff;
  logic [TCW-1:0] tc;
  logic           overflow, ref_closed;
  logic           ref_room, tgt_room;

  assign rc_eff   = ref_closed ? '0 : rc;
  assign ref_room = (rc_eff < RCW'(MAX_REFERENCE_POINTS));
  assign tgt_room = (tc < TCW'(MAX_TARGET_POINTS));

  // point counts and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rc         <= '0;
      tc         <= '0;
      overflow   <= 1'b0;
      ref_closed <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (!in_kind) begin
          ref_closed <= in_last;
          if (ref_room) begin
            rc <= rc_eff + 1'b1;
          end else begin
            rc       <= rc_eff;
            overflow <= 1'b1;
          end
        end else begin
          if (tgt_room) begin
            tc <= tc + 1'b1;
          end else begin
            overflow <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        tc       <= '0;
        overflow <= 1'b0;
      end
    end
  end

  // step counters
  logic [TCW-1:0] i;
  logic [RCW-1:0] j;
  logic [1:0]     k;
  logic [ITW-1:0] it;
  logic           issue;

  assign issue = cmd.scan && (j < rc);

  always_ff @(posedge clk) begin
    if (cmd.clr_step || cmd.div_store) i <= '0;
    else if (cmd.match || cmd.x_next) i <= i + 1'b1;
    if (cmd.t_read) j <= '0;
    else if (issue) j <= j + 1'b1;
    if (cmd.clr_step || cmd.x_ctr || cmd.sc_fin) k <= '0;
    else if (cmd.div_store || cmd.x_mul || cmd.f_mul) k <= k + 1'b1;
    if (cmd.vec_load || cmd.sc_init) it <= '0;
    else if (cmd.vec_step || cmd.rot_step) it <= it + 1'b1;
  end

  // store writes and registered reads
  icp_pkg::pt_t t_q, m_q, ref_q;

  always_ff @(posedge clk) begin
    if (cmd.load && !in_kind && ref_room) ref_mem[rc_eff[RAW-1:0]] <= {in_x, in_y};
    if (cmd.load && in_kind && tgt_room) tgt_mem[tc[TAW-1:0]] <= {in_x, in_y};
    if (issue) ref_q <= ref_mem[j[RAW-1:0]];
    if (cmd.t_read || cmd.x_read) t_q <= tgt_mem[i[TAW-1:0]];
  end

  icp_pkg::pt_t best_pt;

  always_ff @(posedge clk) begin
    if (cmd.match) mat_mem[i[TAW-1:0]] <= best_pt;
    if (cmd.x_read) m_q <= mat_mem[i[TAW-1:0]];
  end

  // nearest reference search pipeline: read, difference, square, compare
  logic           va, vb, vc, first_a, first_b, first_c;
  icp_pkg::pt_t   pt_b, pt_c;
  logic [31:0]    dxm, dym;
  logic [63:0]    sqa, sqb;
  logic [64:0]    sq_dist, best_d;

  assign sq_dist = {1'b0, sqa} + {1'b0, sqb};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= issue;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    first_a <= (j == '0);
    first_b <= first_a;
    first_c <= first_b;
    dxm     <= mag33(33'(t_q.x) - 33'(ref_q.x));
    dym     <= mag33(33'(t_q.y) - 33'(ref_q.y));
    pt_b    <= ref_q;
    sqa     <= dxm * dxm;
    sqb     <= dym * dym;
    pt_c    <= pt_b;
    if (vc && (first_c || sq_dist < best_d)) begin
      best_d  <= sq_dist;
      best_pt <= pt_c;
    end
  end

  // centroid sums and shared divider
  logic signed [SUMW-1:0] csum [4];
  logic signed [31:0]     mean [4];
  logic [SUMW-1:0]        dq;
  logic [TCW-1:0]         rem;
  logic [TCW:0]           rem_t;
  logic [DCW-1:0]         dcnt;
  logic                   dneg;
  logic signed [SUMW-1:0] dsel, qv;

  assign dsel  = csum[k];
  assign rem_t = {rem, dq[SUMW-1]};
  assign qv    = dneg ? -$signed(dq) : $signed(dq);

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      csum[0] <= '0;
      csum[1] <= '0;
      csum[2] <= '0;
      csum[3] <= '0;
    end else if (cmd.match) begin
      csum[0] <= csum[0] + SUMW'(t_q.x);
      csum[1] <= csum[1] + SUMW'(t_q.y);
      csum[2] <= csum[2] + SUMW'(best_pt.x);
      csum[3] <= csum[3] + SUMW'(best_pt.y);
    end
    if (cmd.div_start) begin
      dq   <= dsel[SUMW-1] ? $unsigned(-dsel) : $unsigned(dsel);
      dneg <= dsel[SUMW-1];
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + 1'b1;
      if (rem_t >= {1'b0, tc}) begin
        rem <= TCW'(rem_t - {1'b0, tc});
        dq  <= {dq[SUMW-2:0], 1'b1};
      end else begin
        rem <= rem_t[TCW-1:0];
        dq  <= {dq[SUMW-2:0], 1'b0};
      end
    end
    if (cmd.div_store) mean[k] <= qv[31:0];
  end

  // centred cross-sums, one product per cycle
  logic signed [32:0] bx, by, ax, ay, xa, xb;
  logic [63:0]        xprod;
  logic               xneg, xpv;
  logic [1:0]         xpk;
  logic signed [63:0] xsum [4];
  logic signed [63:0] xterm;

  always_comb begin
    case (k)
      2'd0:    begin xa = bx; xb = ay; end
      2'd1:    begin xa = by; xb = ax; end
      2'd2:    begin xa = bx; xb = ax; end
      default: begin xa = by; xb = ay; end
    endcase
  end

  assign xterm = xneg ? -$signed({16'b0, xprod[63:16]}) : $signed({16'b0, xprod[63:16]});

  always_ff @(posedge clk) begin
    if (rst) xpv <= 1'b0;
    else     xpv <= cmd.x_mul;
  end

  always_ff @(posedge clk) begin
    if (cmd.x_ctr) begin
      bx <= 33'(t_q.x) - 33'(mean[0]);
      by <= 33'(t_q.y) - 33'(mean[1]);
      ax <= 33'(m_q.x) - 33'(mean[2]);
      ay <= 33'(m_q.y) - 33'(mean[3]);
    end
    xprod <= mag33(xa) * mag33(xb);
    xneg  <= xa[32] ^ xb[32];
    xpk   <= k;
    if (cmd.clr_step) begin
      xsum[0] <= '0;
      xsum[1] <= '0;
      xsum[2] <= '0;
      xsum[3] <= '0;
    end else if (xpv) begin
      xsum[xpk] <= xsum[xpk] + xterm;
    end
  end

  // shared cordic for atan2 (vectoring) and sin/cos (rotation)
  logic signed [64:0]   vx, vy;
  logic                 yzero, flip;
  logic signed [CW-1:0] cx, cy, xs, ys;
  logic signed [ZW-1:0] cz, za, zin;
  logic signed [31:0]   ang;
  logic                 pos;

  assign xs  = cx >>> it;
  assign ys  = cy >>> it;
  assign za  = ZW'($signed(icp_pkg::atan_q29(5'(it))));
  assign pos = cmd.vec_step ? (cy > 0) : (cz < 0);
  assign zin = ZW'(ang);

  always_ff @(posedge clk) begin
    if (cmd.ang_init) begin
      vx    <= 65'(xsum[2]) + 65'(xsum[3]);
      vy    <= 65'(xsum[0]) - 65'(xsum[1]);
      yzero <= (xsum[0] == xsum[1]);
    end else if (cmd.ang_half) begin
      vx <= halve(vx);
      vy <= halve(vy);
    end
    if (cmd.vec_load) begin
      if (vx[64]) begin
        cx <= CW'(-vx);
        cy <= CW'(-vy);
        cz <= vy[64] ? -PI_Z : PI_Z;
      end else begin
        cx <= CW'(vx);
        cy <= CW'(vy);
        cz <= '0;
      end
    end else if (cmd.sc_init) begin
      cx <= CW'(icp_pkg::GAIN_Q30);
      cy <= '0;
      if (zin > HP_Z) begin
        cz   <= zin - PI_Z;
        flip <= 1'b1;
      end else if (zin < -HP_Z) begin
        cz   <= zin + PI_Z;
        flip <= 1'b1;
      end else begin
        cz   <= zin;
        flip <= 1'b0;
      end
    end else if (cmd.vec_step || cmd.rot_step) begin
      if (pos) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + za;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - za;
      end
    end
    if (cmd.ang_set) begin
      if (yzero)            ang <= vx[64] ? icp_pkg::PI_Q29 : 32'sd0;
      else if (cz > PI_Z)   ang <= icp_pkg::PI_Q29;
      else if (cz < -PI_Z)  ang <= -icp_pkg::PI_Q29;
      else                  ang <= cz[31:0];
    end
  end

  // rotated centroid, one product per cycle
  logic signed [ZW-1:0] cc, ss, fb;
  logic signed [31:0]   fa;
  logic signed [65:0]   fprod;
  logic                 fpv;
  logic [1:0]           fk;
  logic signed [67:0]   facc_x, facc_y;
  logic signed [37:0]   rx, ry;

  assign fa = (k == 2'd0 || k == 2'd2) ? mean[0] : mean[1];
  assign fb = (k == 2'd0 || k == 2'd3) ? cc : ss;
  assign rx = 38'(facc_x >>> 30);
  assign ry = 38'(facc_y >>> 30);

  always_ff @(posedge clk) begin
    if (rst) fpv <= 1'b0;
    else     fpv <= cmd.f_mul;
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_fin) begin
      cc     <= flip ? ZW'(-cx) : ZW'(cx);
      ss     <= flip ? ZW'(-cy) : ZW'(cy);
      facc_x <= '0;
      facc_y <= '0;
    end else if (fpv) begin
      case (fk)
        2'd0:    facc_x <= facc_x + 68'(fprod);
        2'd1:    facc_x <= facc_x - 68'(fprod);
        default: facc_y <= facc_y + 68'(fprod);
      endcase
    end
    fprod <= fa * fb;
    fk    <= k;
  end

  // result register
  logic empty_q;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) empty_q <= sts.start_empty;
    if (cmd.out_load) begin
      if (empty_q) begin
        shift_x <= '0;
        shift_y <= '0;
        angle   <= '0;
        status  <= icp_pkg::STATUS_EMPTY;
      end else begin
        shift_x <= sat32(40'(mean[2]) - 40'(rx));
        shift_y <= sat32(40'(mean[3]) - 40'(ry));
        angle   <= ang;
        status  <= overflow ? icp_pkg::STATUS_DROP : icp_pkg::STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    sts.start_empty = (rc == '0) || (tc == '0);
    sts.i_last      = (TCW'(i + 1'b1) == tc);
    sts.scan_done   = !(j < rc) && !va && !vb && !vc;
    sts.div_done    = (dcnt == DCW'(SUMW));
    sts.k_last      = (k == 2'd3);
    sts.y_zero      = yzero;
    sts.need_half   = (vx >= LIM59) || (vx <= -LIM59) || (vy >= LIM59) || (vy <= -LIM59);
    sts.it_last     = (it == ITW'(CORDIC_ITERATIONS - 1));
    sts.out_busy    = out_valid && !out_ready;
  end

endmodule

>>> sv/icp_checker.sv
module icp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] shift_x,
  input logic signed [31:0] shift_y,
  input logic signed [31:0] angle,
  input logic [1:0]         status
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shift_x) && $stable(shift_y)
      && $stable(angle) && $stable(status))
    else $error("result changed while stalled");

  // only defined status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == icp_pkg::STATUS_OK || status == icp_pkg::STATUS_EMPTY
      || status == icp_pkg::STATUS_DROP)
    else $error("undefined status code");

  // an empty set gives a zero transform
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == icp_pkg::STATUS_EMPTY |-> shift_x == 0 && shift_y == 0
      && angle == 0)
    else $error("empty set with nonzero transform");

  // angle stays within plus or minus pi
  a_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle <= icp_pkg::PI_Q29 && angle >= -icp_pkg::PI_Q29)
    else $error("angle out of range");

endmodule

bind icp_2d_alignment_step icp_checker u_icp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .shift_x   (result.shift_x),
  .shift_y   (result.shift_y),
  .angle     (result.angle),
  .status    (result.status)
);
